@@ rtl/bsd_pkg.sv @@
package bsd_pkg;

	// pad character of the base64 alphabet
	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// default depth of the group queue between front and back
	localparam int DEF_FIFO_DEPTH = 4;

	// byte count of one group, 1 to 3
	typedef logic [1:0] bsd_count_t;

	localparam bsd_count_t FULL_GROUP = 2'd3;
	localparam bsd_count_t ONE_BYTE   = 2'd1;

	// one finished group, handed from front to back
	typedef struct packed {
		logic [23:0] triple;
		bsd_count_t  count;
		logic        last;
		logic        len_err;
		logic        bad;
	} bsd_group_t;

endpackage

@@ rtl/bsd_front.sv @@
module bsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        in_char,
	input  logic              in_last,
	input  logic              q_full,
	output logic              push,
	output bsd_pkg::bsd_group_t grp
);
	import bsd_pkg::*;

	logic [1:0]  pos_q;
	logic [17:0] acc_q;
	logic        third_pad_q;
	logic        bad_q;

	logic        accept;
	logic [5:0]  sextet;
	logic        char_bad;
	logic        badbit;
	logic        is_pad;
	logic        drop4;
	logic        drop3;

	// alphabet lookup
	always_comb begin
		char_bad = 1'b0;
		sextet   = 6'd0;
		if (in_char inside {[8'h41:8'h5A]}) begin
			sextet = 6'(in_char - 8'h41);
		end else if (in_char inside {[8'h61:8'h7A]}) begin
			sextet = 6'(in_char - 8'd71);
		end else if (in_char inside {[8'h30:8'h39]}) begin
			sextet = 6'(in_char + 8'd4);
		end else if (in_char == 8'h2B) begin
			sextet = 6'd62;
		end else if (in_char == 8'h2F) begin
			sextet = 6'd63;
		end else if (in_char != PAD_CHAR) begin
			char_bad = 1'b1;
		end
	end

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign is_pad   = (in_char == PAD_CHAR);
	assign badbit   = bad_q | char_bad;
	assign push     = accept && ((pos_q == 2'd3) || in_last);

	// group entry for the queue
	assign drop4 = in_last && is_pad;
	assign drop3 = in_last && third_pad_q;
	always_comb begin
		grp.last = in_last;
		grp.bad  = badbit;
		if (pos_q == 2'd3) begin
			grp.triple  = {acc_q, sextet};
			grp.count   = FULL_GROUP - bsd_count_t'(drop4) - bsd_count_t'(drop3);
			grp.len_err = 1'b0;
		end else begin
			grp.triple  = 24'd0;
			grp.count   = ONE_BYTE;
			grp.len_err = 1'b1;
		end
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q       <= 2'd0;
			acc_q       <= 18'd0;
			third_pad_q <= 1'b0;
			bad_q       <= 1'b0;
		end else if (accept) begin
			if (push) begin
				pos_q       <= 2'd0;
				acc_q       <= 18'd0;
				third_pad_q <= 1'b0;
				bad_q       <= 1'b0;
			end else begin
				pos_q <= pos_q + 2'd1;
				acc_q <= {acc_q[11:0], sextet};
				bad_q <= badbit;
				if (pos_q == 2'd2 && is_pad) begin
					third_pad_q <= 1'b1;
				end
			end
		end
	end

endmodule

@@ rtl/bsd_fifo.sv @@
module bsd_fifo #(
	parameter int DEPTH = bsd_pkg::DEF_FIFO_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bsd_pkg::bsd_group_t wr_data,
	output logic              full,
	input  logic              pop,
	output logic              head_valid,
	output bsd_pkg::bsd_group_t head
);
	import bsd_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bsd_group_t         mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/bsd_back.sv @@
module bsd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  bsd_pkg::bsd_group_t head,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last,
	output logic              length_error,
	output logic              bad_char
);
	import bsd_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       last_q;
	logic       err_q;
	logic       bad_q;

	logic       load;
	logic       group_end;
	logic [7:0] sel_byte;

	assign load      = head_valid && (!valid_q || out_ready);
	assign group_end = ((idx_q + 2'd1) == head.count);
	assign pop       = load && group_end;

	// byte select, most significant first
	always_comb begin
		case (idx_q)
			2'd0:    sel_byte = head.triple[23:16];
			2'd1:    sel_byte = head.triple[15:8];
			2'd2:    sel_byte = head.triple[7:0];
			default: sel_byte = 8'd0;
		endcase
	end

	// byte index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= 2'd0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= group_end ? 2'd0 : idx_q + 2'd1;
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			last_q <= head.last && group_end;
			err_q  <= head.len_err;
			bad_q  <= head.bad;
		end
	end

	assign out_valid    = valid_q;
	assign out_byte     = byte_q;
	assign out_last     = last_q;
	assign length_error = err_q;
	assign bad_char     = bad_q;

endmodule

@@ rtl/base64_stream_decoder.sv @@
// channel  | direction | tdata             | tlast          | tuser
// s_axis   | in        | [7:0] in_char     | in_last        | -
// m_axis   | out       | [7:0] out_byte    | out_last       | [0] length_error, [1] bad_char
//
// one character per cycle in; one byte per cycle out, three per full group
// a completed group is written into the group queue, and each of its bytes
// then into the output register
// the front stalls only when the group queue is full, the back only on m_tready
// arst_n clears group state, queue pointers and the output valid
module base64_stream_decoder #(
	parameter int FIFO_DEPTH = bsd_pkg::DEF_FIFO_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] in_char
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] out_byte
	output logic       m_tlast,
	output logic [1:0] m_tuser    // [0] length_error, [1] bad_char
);
	import bsd_pkg::*;

	bsd_group_t grp;
	bsd_group_t head;
	logic       push;
	logic       q_full;
	logic       pop;
	logic       head_valid;

	// character intake and grouping
	bsd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_char  (s_tdata),
		.in_last  (s_tlast),
		.q_full   (q_full),
		.push     (push),
		.grp      (grp)
	);

	// group queue
	bsd_fifo #(
		.DEPTH (FIFO_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.wr_data    (grp),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	// byte output
	bsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.out_last     (m_tlast),
		.length_error (m_tuser[0]),
		.bad_char     (m_tuser[1])
	);

	// no group is pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("group pushed into full queue");

	// a group leaves the queue only when one is there
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("group popped from empty queue");

	// queued groups carry a byte count of one to three
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> (head.count != 2'd0))
		else $error("queued group with zero bytes");

	// a length-error result is the zero, final result
	a_err_result: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tlast && (m_tdata == 8'd0)))
		else $error("malformed length error result");

endmodule
